[rtl/paper_tape_hex_record_loader_assert.svh]
// Assertion macros for the tape loader.
`ifndef PAPER_TAPE_HEX_RECORD_LOADER_ASSERT_SVH
`define PAPER_TAPE_HEX_RECORD_LOADER_ASSERT_SVH

// Same-cycle implication.
`define PTL_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication.
`define PTL_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

[rtl/ptl_pkg.sv]
`timescale 1ns / 1ps

package ptl_pkg;

    localparam logic [7:0] SEMICOLON = 8'h3B;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_CKSUM
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] computed_sum;
        logic        error_seen;
        logic        done_seen;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/ptl_in_stage.sv]
`timescale 1ns / 1ps

module ptl_in_stage
    import ptl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_stall,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_take) begin
            r_item <= i_item;
        end
    end

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/ptl_parse.sv]
`timescale 1ns / 1ps

module ptl_parse
    import ptl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_digit,  n_digit;
    logic [15:0] r_shift,  n_shift;
    logic [7:0]  r_left,   n_left;
    logic [15:0] r_addr,   n_addr;
    logic [15:0] r_sum,    n_sum;
    logic        r_err,    n_err;
    logic        r_done,   n_done;
    logic [15:0] r_start,  n_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_digit <= 2'd0;
            r_shift <= 16'd0;
            r_left  <= 8'd0;
            r_addr  <= 16'd0;
            r_sum   <= 16'd0;
            r_err   <= 1'b0;
            r_done  <= 1'b0;
            r_start <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_digit <= n_digit;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_addr  <= n_addr;
            r_sum   <= n_sum;
            r_err   <= n_err;
            r_done  <= n_done;
            r_start <= n_start;
        end
    end

    always_comb begin
        t_hex        hx;
        logic [15:0] shifted;
        logic        last;
        logic        emit;
        t_kind       kind;
        logic [15:0] addr_out;
        logic [7:0]  data_out;
        logic [7:0]  left_dec;

        n_phase = i_item.opcode ? PH_HUNT : r_phase;
        n_digit = i_item.opcode ? 2'd0 : r_digit;
        n_shift = i_item.opcode ? 16'd0 : r_shift;
        n_err   = i_item.opcode ? 1'b0 : r_err;
        n_done  = i_item.opcode ? 1'b0 : r_done;
        n_left  = r_left;
        n_addr  = r_addr;
        n_sum   = r_sum;
        n_start = r_start;

        hx       = hex_digit(i_item.char_in);
        shifted  = {n_shift[11:0], hx.value};
        left_dec = r_left - 8'd1;
        last     = 1'b0;
        emit     = 1'b0;
        kind     = KIND_WRITE;
        addr_out = 16'd0;
        data_out = 8'd0;

        if (n_phase == PH_HUNT) begin
            if (i_item.char_in == SEMICOLON) begin
                n_phase = PH_COUNT;
                n_digit = 2'd0;
                n_shift = 16'd0;
                n_left  = 8'd0;
                n_addr  = 16'd0;
                n_sum   = 16'd0;
                n_start = 16'd0;
            end
        end else if (!hx.valid) begin
            n_err    = 1'b1;
            n_phase  = PH_HUNT;
            n_digit  = 2'd0;
            n_shift  = 16'd0;
            emit     = 1'b1;
            kind     = KIND_BAD;
            addr_out = r_start;
        end else begin
            last = (n_phase == PH_ADDR || n_phase == PH_CKSUM) ?
                   (n_digit == 2'd3) : (n_digit == 2'd1);
            if (!last) begin
                n_digit = n_digit + 2'd1;
                n_shift = shifted;
            end else begin
                n_digit = 2'd0;
                n_shift = 16'd0;
                case (n_phase)
                    PH_COUNT: begin
                        if (shifted == 16'd0) begin
                            n_done  = 1'b1;
                            n_phase = PH_HUNT;
                            emit    = 1'b1;
                            kind    = KIND_END;
                        end else begin
                            n_sum   = r_sum + shifted;
                            n_left  = shifted[7:0];
                            n_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        n_addr  = shifted;
                        n_start = shifted;
                        n_sum   = r_sum + {8'd0, shifted[15:8]} + {8'd0, shifted[7:0]};
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        n_sum    = r_sum + shifted;
                        n_addr   = r_addr + 16'd1;
                        n_left   = left_dec;
                        if (left_dec == 8'd0) begin
                            n_phase = PH_CKSUM;
                        end
                        emit     = 1'b1;
                        kind     = KIND_WRITE;
                        addr_out = r_addr;
                        data_out = shifted[7:0];
                    end
                    default: begin
                        n_phase  = PH_HUNT;
                        emit     = 1'b1;
                        addr_out = r_start;
                        if (shifted == r_sum) begin
                            kind = KIND_GOOD;
                        end else begin
                            n_err = 1'b1;
                            kind  = KIND_BAD;
                        end
                    end
                endcase
            end
        end

        o_res_valid         = i_step && emit;
        o_res.kind          = kind;
        o_res.write_address = addr_out;
        o_res.write_data    = data_out;
        o_res.computed_sum  = n_sum;
        o_res.error_seen    = n_err;
        o_res.done_seen     = n_done;
    end

endmodule

[rtl/ptl_out_stage.sv]
`timescale 1ns / 1ps

module ptl_out_stage
    import ptl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic      i_res_valid,
    input  t_out_item i_res,
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/paper_tape_hex_record_loader.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One character per cycle unless the output stalls; both ends are registered.
// The parser state updates when a character leaves the input register.
// Synchronous active-low reset clears both stages and the parser state.
// A stalled output holds its result; the input register keeps its character
// and o_in_stall rises only while both stages are full and the output waits.
`timescale 1ns / 1ps

module paper_tape_hex_record_loader
    import ptl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    `include "paper_tape_hex_record_loader_assert.svh"

    logic      w_advance;
    logic      w_in_valid;
    t_in_item  w_in_item;
    logic      w_res_valid;
    t_out_item w_res;

    assign w_advance = !o_out_valid || !i_out_stall;

    ptl_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_take  (w_advance),
        .o_stall (o_in_stall),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    ptl_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_in_valid && w_advance),
        .i_item      (w_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ptl_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item)
    );

    `PTL_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, w_in_valid && o_out_valid && i_out_stall, "input stalled without a full pipeline")
    `PTL_ASSERT_NEXT(a_held_char, i_clk, i_rst_n, w_in_valid && o_in_stall, w_in_valid, "held character dropped")
    `PTL_ASSERT_NOW(a_end_fields, i_clk, i_rst_n, o_out_valid && o_out_item.kind == KIND_END, o_out_item.done_seen && o_out_item.write_address == 16'd0 && o_out_item.write_data == 8'd0, "end record fields wrong")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ptl_pkg::*;

    typedef struct packed {
        logic        op;
        logic [7:0]  ch;
        logic        typed;
        t_kind       kind;
        logic [15:0] addr;
        logic [15:0] sum;
        logic        err;
        logic        done;
    } t_tape_row;

    typedef struct {
        bit        typed;
        t_out_item want;
    } t_row_mark;

    localparam int PLAN_ROWS = 25;
    localparam int HOLD_CYCLES = 200;

    // op, char, typed, kind, address, sum, error, done
    localparam t_tape_row TAPE_PLAN [PLAN_ROWS] = '{
        '{1'b0, "x",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 8'h00, 1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, ";",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "0",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "0",   1'b1, KIND_END,   16'h0000, 16'h0000, 1'b0, 1'b1},
        '{1'b1, ";",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "G",   1'b1, KIND_BAD,   16'h0000, 16'h0000, 1'b1, 1'b0},
        '{1'b0, ";",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "0",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "1",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "F",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "F",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "f",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "F",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "f",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "F",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "0",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "2",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "f",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "E",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, ";",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 8'hFF, 1'b1, KIND_BAD,   16'h0000, 16'h0000, 1'b1, 1'b0},
        '{1'b1, 8'h80, 1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, ";",   1'b0, KIND_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{1'b0, "z",   1'b1, KIND_BAD,   16'h0000, 16'h0000, 1'b1, 1'b0}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    bit        tx_idle = 1'b0;
    bit        rx_idle = 1'b0;
    bit        hold_request = 1'b0;
    int        items_sent = 0;
    int        mismatch_count = 0;

    t_out_item expected_events[$];
    t_row_mark row_marks[$];
    t_in_item  record_chars[$];

    // parser state mirror
    t_phase      pr_phase = PH_HUNT;
    logic [1:0]  pr_digit = '0;
    logic [15:0] pr_shift = '0;
    logic [7:0]  pr_bytes = '0;
    logic [15:0] pr_addr = '0;
    logic [15:0] pr_sum = '0;
    logic [15:0] pr_start = '0;
    logic        pr_err = 1'b0;
    logic        pr_done = 1'b0;

    paper_tape_hex_record_loader dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic t_in_item tape_item(input logic op, input logic [7:0] c);
        t_in_item it;
        it.opcode = op;
        it.char_in = c;
        return it;
    endfunction

    function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
        end else if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return "0" + n;
        end
        return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] unused;
        do c = 8'($urandom); while (nibble_of(c, unused));
        return c;
    endfunction

    function automatic bit tape_parse_step(input t_in_item it, output t_out_item ev);
        logic [3:0]  nib;
        logic [15:0] val;
        int          need;
        bit          emitted;
        emitted = 1'b0;
        ev = '0;
        if (it.opcode) begin
            pr_err = 1'b0;
            pr_done = 1'b0;
            pr_phase = PH_HUNT;
            pr_digit = '0;
            pr_shift = '0;
        end
        if (pr_phase == PH_HUNT) begin
            if (it.char_in == SEMICOLON) begin
                pr_phase = PH_COUNT;
                pr_digit = '0;
                pr_shift = '0;
                pr_bytes = '0;
                pr_addr = '0;
                pr_sum = '0;
                pr_start = '0;
            end
        end else if (!nibble_of(it.char_in, nib)) begin
            pr_err = 1'b1;
            pr_phase = PH_HUNT;
            pr_digit = '0;
            pr_shift = '0;
            emitted = 1'b1;
            ev.kind = KIND_BAD;
            ev.write_address = pr_start;
        end else begin
            pr_shift = {pr_shift[11:0], nib};
            need = (pr_phase == PH_COUNT || pr_phase == PH_DATA) ? 2 : 4;
            if (int'(pr_digit) + 1 < need) begin
                pr_digit = pr_digit + 2'd1;
            end else begin
                pr_digit = '0;
                val = pr_shift;
                pr_shift = '0;
                case (pr_phase)
                    PH_COUNT: begin
                        if (val == 16'd0) begin
                            pr_done = 1'b1;
                            pr_phase = PH_HUNT;
                            emitted = 1'b1;
                            ev.kind = KIND_END;
                        end else begin
                            pr_sum = pr_sum + val;
                            pr_bytes = val[7:0];
                            pr_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        pr_addr = val;
                        pr_start = val;
                        pr_sum = pr_sum + {8'h00, val[15:8]} + {8'h00, val[7:0]};
                        pr_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        emitted = 1'b1;
                        ev.kind = KIND_WRITE;
                        ev.write_address = pr_addr;
                        ev.write_data = val[7:0];
                        pr_sum = pr_sum + val;
                        pr_addr = pr_addr + 16'd1;
                        pr_bytes = pr_bytes - 8'd1;
                        if (pr_bytes == 8'd0) begin
                            pr_phase = PH_CKSUM;
                        end
                    end
                    default: begin
                        pr_phase = PH_HUNT;
                        emitted = 1'b1;
                        ev.write_address = pr_start;
                        if (val == pr_sum) begin
                            ev.kind = KIND_GOOD;
                        end else begin
                            pr_err = 1'b1;
                            ev.kind = KIND_BAD;
                        end
                    end
                endcase
            end
        end
        ev.computed_sum = pr_sum;
        ev.error_seen = pr_err;
        ev.done_seen = pr_done;
        return emitted;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_char(input t_in_item item, input bit typed, input t_out_item want);
        t_row_mark mark;
        mark.typed = typed;
        mark.want = want;
        row_marks.push_back(mark);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        items_sent++;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic push_hex(input logic [15:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--) begin
            record_chars.push_back(tape_item(1'b0, hex_char(v[4*i +: 4])));
        end
    endtask

    // mostly well-formed records, some noise, some records broken midway
    task automatic feed_record();
        int          roll;
        int          n_bytes;
        int          open_at;
        int          pos;
        logic [15:0] base;
        logic [15:0] csum;
        logic [7:0]  b;
        record_chars.delete();
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            repeat ($urandom_range(1, 12)) begin
                record_chars.push_back(tape_item($urandom_range(0, 15) == 0, 8'($urandom)));
            end
        end else begin
            repeat ($urandom_range(0, 2)) begin
                b = 8'($urandom);
                if (b == SEMICOLON) begin
                    b = ~b;
                end
                record_chars.push_back(tape_item(1'b0, b));
            end
            open_at = record_chars.size();
            record_chars.push_back(tape_item($urandom_range(0, 19) == 0, SEMICOLON));
            n_bytes = $urandom_range(0, 99);
            if (n_bytes < 6) begin
                n_bytes = 0;
            end else if (n_bytes == 99) begin
                n_bytes = $urandom_range(128, 255);
            end else begin
                n_bytes = $urandom_range(1, 8);
            end
            push_hex(16'(n_bytes), 2);
            if (n_bytes != 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    base = 16'hFFFF - 16'($urandom_range(0, 7));
                end else begin
                    base = 16'($urandom);
                end
                push_hex(base, 4);
                csum = 16'(n_bytes) + base[15:8] + base[7:0];
                repeat (n_bytes) begin
                    b = 8'($urandom);
                    push_hex({8'h00, b}, 2);
                    csum = csum + b;
                end
                if ($urandom_range(0, 9) == 0) begin
                    csum = csum ^ 16'($urandom_range(1, 65535));
                end
                push_hex(csum, 4);
            end
            if (roll >= 80) begin
                pos = $urandom_range(open_at + 1, record_chars.size() - 1);
                if ($urandom_range(0, 3) == 0) begin
                    record_chars[pos].opcode = 1'b1;
                end else begin
                    record_chars[pos].char_in = non_hex_char();
                end
            end
        end
        foreach (record_chars[i]) begin
            send_char(record_chars[i], 1'b0, '0);
        end
    endtask

    task automatic feed_until(input int target, input bit idling);
        while (items_sent < target) begin
            if (!idling) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                tx_idle = $urandom_range(0, 1);
                rx_idle = $urandom_range(0, 1);
            end
            feed_record();
        end
    endtask

    // result receiver
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 18)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        t_out_item ev;
        t_out_item want;
        t_row_mark mark;
        bit        emitted;
        if (rst_n) begin
            if (out_valid === 1'b1 && !out_stall) begin
                if (expected_events.size() == 0) begin
                    flag_mismatch("result with nothing expected", 32'(out_item.kind), 32'd0);
                end else begin
                    want = expected_events.pop_front();
                    if (out_item.kind !== want.kind)
                        flag_mismatch("kind", 32'(out_item.kind), 32'(want.kind));
                    if (out_item.write_address !== want.write_address)
                        flag_mismatch("write_address", 32'(out_item.write_address),
                                      32'(want.write_address));
                    if (out_item.write_data !== want.write_data)
                        flag_mismatch("write_data", 32'(out_item.write_data),
                                      32'(want.write_data));
                    if (out_item.computed_sum !== want.computed_sum)
                        flag_mismatch("computed_sum", 32'(out_item.computed_sum),
                                      32'(want.computed_sum));
                    if (out_item.error_seen !== want.error_seen)
                        flag_mismatch("error_seen", 32'(out_item.error_seen),
                                      32'(want.error_seen));
                    if (out_item.done_seen !== want.done_seen)
                        flag_mismatch("done_seen", 32'(out_item.done_seen),
                                      32'(want.done_seen));
                end
            end
            if (in_valid && in_stall === 1'b0) begin
                mark = row_marks.pop_front();
                emitted = tape_parse_step(in_item, ev);
                if (mark.typed) begin
                    expected_events.push_back(mark.want);
                end else if (emitted) begin
                    expected_events.push_back(ev);
                end
            end
        end
    end

    initial begin
        t_tape_row row;
        t_out_item want;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            row = TAPE_PLAN[r];
            want.kind = row.kind;
            want.write_address = row.addr;
            want.write_data = 8'h00;
            want.computed_sum = row.sum;
            want.error_seen = row.err;
            want.done_seen = row.done;
            send_char(tape_item(row.op, row.ch), row.typed, want);
        end

        feed_until(700, 1'b1);

        // drain fully before going on
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_events.size() != 0);

        // long receiver hold-off while characters keep coming
        tx_idle = 1'b0;
        hold_request = 1'b1;
        while (hold_request) begin
            feed_record();
        end

        feed_until(1400, 1'b1);
        feed_until(1750, 1'b0);

        in_valid <= 1'b0;
        do @(posedge clk); while (expected_events.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ptl_pkg.sv
rtl/ptl_in_stage.sv
rtl/ptl_parse.sv
rtl/ptl_out_stage.sv
rtl/paper_tape_hex_record_loader.sv
test/tb_top.sv
